FILE: sv/dwm_pkg.sv
// Shared types, constants and helper functions of the dictionary word masker.
package dwm_pkg;

  localparam int MSG_LEN_DEF      = 64;
  localparam int PAT_LEN_DEF      = 16;
  localparam int NUM_PATTERNS_DEF = 64;

  localparam int         CNT_W   = 7;
  localparam logic [6:0] CNT_MAX = 7'd127;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_MSG    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_LOW_W = 8'h77;
  localparam logic [7:0] CHAR_UP_W  = 8'h57;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [2:0] PICK_MAX = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP,
    ST_WRITE,
    ST_PREP,
    ST_SLOT,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctrl_t;

  function automatic logic [7:0] mask_char(input logic [2:0] pick);
    logic [7:0] c;
    case (pick)
      3'd0:    c = 8'h40;
      3'd1:    c = 8'h23;
      3'd2:    c = 8'h24;
      3'd3:    c = 8'h2A;
      default: c = 8'h26;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'd32;
    return r;
  endfunction

endpackage

FILE: sv/dictionary_word_masker_unit.sv
// Top level of the dictionary word masker: control sequencer and message cell ring.
// Pattern and non-last message bytes are accepted while idle. An add or remove walks its list
// slot by slot (fetch, compare), then an add that finds no match writes the pattern. A last message
// byte starts a prefix scan of the ring, then a check, fetch and ring rotation per valid slot
// (empty slots are stepped over), then the output transfers, which out_stall can hold.
// Synchronous reset empties both lists, clears the byte count and the mask flags.
module dictionary_word_masker_unit #(
  parameter int MSG_LEN      = dwm_pkg::MSG_LEN_DEF,
  parameter int PAT_LEN      = dwm_pkg::PAT_LEN_DEF,
  parameter int NUM_PATTERNS = dwm_pkg::NUM_PATTERNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  input  logic       list_sel,
  input  logic [2:0] mask_pick,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       was_masked
);

  localparam int SLOTS = 2 * NUM_PATTERNS;
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = $clog2(SLOTS * PAT_LEN);
  localparam int LW    = $clog2(PAT_LEN + 1);
  localparam int IW    = $clog2(PAT_LEN);
  localparam int NW    = $clog2(MSG_LEN + 1);
  localparam int PW    = $clog2(MSG_LEN);

  dwm_pkg::state_t state, state_next;

  logic [dwm_pkg::CNT_W-1:0] count;
  logic [dwm_pkg::CNT_W-1:0] cnt_inc;
  logic                      mode_add, mode_scan;
  logic [SW-1:0]             slot, slot_last, free_slot, wslot;
  logic                      free_found;
  logic [LW-1:0]             j, pn;
  logic [NW-1:0]             msg_n, start;
  logic                      skip_all, whisper, seen_space, found2;
  logic [PW-1:0]             pos, k;
  logic [LW-1:0]             skip;
  logic [7:0]                pat  [PAT_LEN];
  logic [7:0]                lbuf [PAT_LEN];
  logic [SLOTS-1:0]          valid;

  logic          acc;
  logic [AW-1:0] raddr, waddr;
  logic [7:0]    rdata;
  logic [LW-1:0] len_rdata;
  logic          we, len_we;
  logic [LW-1:0] j_addr;

  // Cell ring signals.
  logic [7:0]          c_byte [MSG_LEN];
  logic [7:0]          c_low  [MSG_LEN];
  logic [2:0]          c_pick [MSG_LEN];
  logic                c_flag [MSG_LEN];
  logic [MSG_LEN-1:0]  c_wr, c_mark;
  logic [7:0]          win    [PAT_LEN];
  dwm_pkg::cell_ctrl_t ctrl;
  logic [2:0]          pick_sat;

  logic find_eq, find_match, scan_eq, hit, active, fits, out_load;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state != dwm_pkg::ST_IDLE);
  assign cnt_inc  = (count == dwm_pkg::CNT_MAX) ? dwm_pkg::CNT_MAX : count + 1'b1;
  assign pick_sat = (mask_pick > dwm_pkg::PICK_MAX) ? dwm_pkg::PICK_MAX : mask_pick;

  // The fetch runs one step past the pattern so the last read can land.
  assign j_addr = (j == LW'(PAT_LEN)) ? '0 : j;
  assign raddr  = AW'(slot) * AW'(PAT_LEN) + AW'(j_addr);
  assign waddr  = AW'(wslot) * AW'(PAT_LEN) + AW'(j_addr);
  assign we     = (state == dwm_pkg::ST_WRITE);
  assign len_we = we && (j == '0);

  dwm_pat_mem #(.SLOTS(SLOTS), .PAT_LEN(PAT_LEN)) u_mem (
    .clk       (clk),
    .we        (we),
    .waddr     (waddr),
    .wdata     (lbuf[j_addr[IW-1:0]]),
    .raddr     (raddr),
    .rdata     (rdata),
    .len_we    (len_we),
    .len_waddr (wslot),
    .len_wdata (pn),
    .len_raddr (slot),
    .len_rdata (len_rdata)
  );

  // Message ring: cell 0 is the head, every shift moves each cell one place toward it.
  genvar gi;
  generate
    for (gi = 0; gi < MSG_LEN; gi++) begin : g_cell
      assign c_wr[gi]   = acc && (func == dwm_pkg::FUNC_MSG) && (count == dwm_pkg::CNT_W'(gi));
      assign c_mark[gi] = hit && (8'(gi) < 8'(len_rdata));
      dwm_msg_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .wr       (c_wr[gi]),
        .wr_byte  (data_byte),
        .wr_pick  (pick_sat),
        .mark     (c_mark[gi]),
        .nb_byte  (c_byte[(gi + 1) % MSG_LEN]),
        .nb_pick  (c_pick[(gi + 1) % MSG_LEN]),
        .nb_flag  (c_flag[(gi + 1) % MSG_LEN]),
        .cur_byte (c_byte[gi]),
        .low_byte (c_low[gi]),
        .cur_pick (c_pick[gi]),
        .flag_out (c_flag[gi])
      );
    end
    for (gi = 0; gi < PAT_LEN; gi++) begin : g_win
      if (gi < MSG_LEN) begin : g_in
        assign win[gi] = c_low[gi];
      end else begin : g_pad
        assign win[gi] = '0;
      end
    end
  endgenerate

  // Pattern equality for list lookups and for the scan window at the ring head.
  always_comb begin
    find_eq = 1'b1;
    scan_eq = 1'b1;
    for (int i = 0; i < PAT_LEN; i++) begin
      if ((LW'(i) < pn) && (pat[i] != lbuf[i])) find_eq = 1'b0;
      if ((LW'(i) < len_rdata) && (pat[i] != win[i])) scan_eq = 1'b0;
    end
  end

  assign find_match = valid[slot] && (len_rdata == pn) && find_eq;
  assign active     = (NW'(pos) >= start) && (NW'(pos) < msg_n) && (skip == '0);
  assign fits       = (8'(pos) + 8'(len_rdata)) <= 8'(msg_n);
  assign hit        = (state == dwm_pkg::ST_SCAN) && active && fits && scan_eq;
  assign out_load   = (state == dwm_pkg::ST_OUT) && (!out_valid || !out_stall);

  assign ctrl.shift = (state == dwm_pkg::ST_PREP) || (state == dwm_pkg::ST_SCAN) || out_load;
  assign ctrl.clr   = (state == dwm_pkg::ST_PREP) && (pos == '0);

  always_ff @(posedge clk) begin
    if (rst) state <= dwm_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      dwm_pkg::ST_IDLE: begin
        if (acc && is_last && (func == dwm_pkg::FUNC_ADD || func == dwm_pkg::FUNC_REMOVE))
          state_next = dwm_pkg::ST_LOAD;
        else if (acc && is_last && func == dwm_pkg::FUNC_MSG)
          state_next = dwm_pkg::ST_PREP;
      end
      dwm_pkg::ST_LOAD: begin
        if (j == LW'(PAT_LEN))
          state_next = mode_scan ? dwm_pkg::ST_SCAN : dwm_pkg::ST_CMP;
      end
      dwm_pkg::ST_CMP: begin
        if (find_match)
          state_next = dwm_pkg::ST_IDLE;
        else if (slot == slot_last)
          state_next = (mode_add && (free_found || !valid[slot])) ?
                       dwm_pkg::ST_WRITE : dwm_pkg::ST_IDLE;
        else
          state_next = dwm_pkg::ST_LOAD;
      end
      dwm_pkg::ST_WRITE: begin
        if (j == LW'(PAT_LEN - 1)) state_next = dwm_pkg::ST_IDLE;
      end
      dwm_pkg::ST_PREP: begin
        if (pos == PW'(MSG_LEN - 1)) state_next = dwm_pkg::ST_SLOT;
      end
      dwm_pkg::ST_SLOT: begin
        if (skip_all)                     state_next = dwm_pkg::ST_OUT;
        else if (valid[slot])             state_next = dwm_pkg::ST_LOAD;
        else if (slot == SW'(SLOTS - 1))  state_next = dwm_pkg::ST_OUT;
      end
      dwm_pkg::ST_SCAN: begin
        if (pos == PW'(MSG_LEN - 1))
          state_next = (slot == SW'(SLOTS - 1)) ? dwm_pkg::ST_OUT : dwm_pkg::ST_SLOT;
      end
      dwm_pkg::ST_OUT: begin
        if (out_load && (NW'(k) == msg_n - 1'b1)) state_next = dwm_pkg::ST_IDLE;
      end
      default: state_next = dwm_pkg::ST_IDLE;
    endcase
  end

  // Control registers that reset must clear: byte count, list valid bits, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (acc) begin
        if (func == dwm_pkg::FUNC_CLEAR) begin
          count <= '0;
          for (int s = 0; s < SLOTS; s++)
            if ((s >= NUM_PATTERNS) == list_sel) valid[s] <= 1'b0;
        end else begin
          count <= is_last ? '0 : cnt_inc;
        end
      end
      if (state == dwm_pkg::ST_CMP && find_match && !mode_add) valid[slot] <= 1'b0;
      if (len_we) valid[wslot] <= 1'b1;
      if (out_load)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (acc && func != dwm_pkg::FUNC_MSG && func != dwm_pkg::FUNC_CLEAR &&
        count < dwm_pkg::CNT_W'(PAT_LEN))
      lbuf[count[IW-1:0]] <= data_byte;

    case (state)
      dwm_pkg::ST_IDLE: begin
        j          <= '0;
        pos        <= '0;
        free_found <= 1'b0;
        mode_add   <= (func == dwm_pkg::FUNC_ADD);
        mode_scan  <= (func == dwm_pkg::FUNC_MSG);
        slot       <= list_sel ? SW'(NUM_PATTERNS) : '0;
        slot_last  <= list_sel ? SW'(SLOTS - 1) : SW'(NUM_PATTERNS - 1);
        pn         <= (cnt_inc < dwm_pkg::CNT_W'(PAT_LEN)) ? LW'(cnt_inc) : LW'(PAT_LEN);
        msg_n      <= (cnt_inc < dwm_pkg::CNT_W'(MSG_LEN)) ? NW'(cnt_inc) : NW'(MSG_LEN);
      end
      dwm_pkg::ST_LOAD: begin
        if (j != '0) begin
          for (int i = 0; i < PAT_LEN - 1; i++) pat[i] <= pat[i+1];
          pat[PAT_LEN-1] <= rdata;
        end
        j    <= (j == LW'(PAT_LEN)) ? '0 : j + 1'b1;
        pos  <= '0;
        skip <= '0;
      end
      dwm_pkg::ST_CMP: begin
        if (!valid[slot] && !free_found) begin
          free_slot  <= slot;
          free_found <= 1'b1;
        end
        wslot <= free_found ? free_slot : slot;
        slot  <= slot + 1'b1;
      end
      dwm_pkg::ST_WRITE: begin
        j <= j + 1'b1;
      end
      dwm_pkg::ST_PREP: begin
        pos  <= pos + 1'b1;
        slot <= '0;
        if (pos == '0) begin
          // A leading slash is a command; slash then w or W is a whisper.
          start      <= (c_byte[0] == dwm_pkg::CHAR_SLASH) ? NW'(1) : '0;
          whisper    <= (c_byte[0] == dwm_pkg::CHAR_SLASH) && (msg_n >= NW'(2)) &&
                        (c_byte[1] == dwm_pkg::CHAR_LOW_W || c_byte[1] == dwm_pkg::CHAR_UP_W);
          skip_all   <= (c_byte[0] == dwm_pkg::CHAR_SLASH) && (msg_n >= NW'(2)) &&
                        (c_byte[1] == dwm_pkg::CHAR_LOW_W || c_byte[1] == dwm_pkg::CHAR_UP_W);
          seen_space <= 1'b0;
          found2     <= 1'b0;
        end else if (whisper && !found2 && (NW'(pos) < msg_n) &&
                     c_byte[0] == dwm_pkg::CHAR_SPACE) begin
          // The filtered part of a whisper starts after its second space.
          seen_space <= 1'b1;
          if (seen_space) begin
            start    <= NW'(pos) + 1'b1;
            skip_all <= 1'b0;
            found2   <= 1'b1;
          end
        end
        k <= '0;
      end
      dwm_pkg::ST_SLOT: begin
        j <= '0;
        if (!valid[slot] && !skip_all) slot <= slot + 1'b1;
      end
      dwm_pkg::ST_SCAN: begin
        pos <= pos + 1'b1;
        if (hit)                          skip <= len_rdata - 1'b1;
        else if (active && c_low[0][7])   skip <= LW'(1);
        else if (skip != '0)              skip <= skip - 1'b1;
        if (pos == PW'(MSG_LEN - 1)) slot <= slot + 1'b1;
      end
      dwm_pkg::ST_OUT: begin
        if (out_load) k <= k + 1'b1;
      end
      default: begin
        j <= '0;
      end
    endcase
  end

  // Output register: one filtered byte per transfer.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte   <= c_flag[0] ? dwm_pkg::mask_char(c_pick[0]) : c_byte[0];
      was_masked <= c_flag[0];
      out_last   <= (NW'(k) == msg_n - 1'b1);
    end
  end

endmodule

FILE: sv/dwm_msg_cell.sv
// One message cell of the rotating ring: byte, mask pick and mask flag.
module dwm_msg_cell (
  input  logic                clk,
  input  logic                rst,
  input  dwm_pkg::cell_ctrl_t ctrl,
  input  logic                wr,
  input  logic [7:0]          wr_byte,
  input  logic [2:0]          wr_pick,
  input  logic                mark,
  input  logic [7:0]          nb_byte,
  input  logic [2:0]          nb_pick,
  input  logic                nb_flag,
  output logic [7:0]          cur_byte,
  output logic [7:0]          low_byte,
  output logic [2:0]          cur_pick,
  output logic                flag_out
);

  logic flag;

  always_ff @(posedge clk) begin
    if (wr) begin
      cur_byte <= wr_byte;
      cur_pick <= wr_pick;
    end else if (ctrl.shift) begin
      cur_byte <= nb_byte;
      cur_pick <= nb_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.clr) begin
      flag <= 1'b0;
    end else if (ctrl.shift) begin
      flag <= nb_flag;
    end
  end

  // A match marks the cell as it leaves toward its neighbor.
  assign flag_out = flag | mark;
  assign low_byte = dwm_pkg::to_lower(cur_byte);

endmodule

FILE: sv/dwm_pat_mem.sv
// Pattern byte memory and pattern length memory, both with registered reads.
module dwm_pat_mem #(
  parameter int SLOTS   = 2 * dwm_pkg::NUM_PATTERNS_DEF,
  parameter int PAT_LEN = dwm_pkg::PAT_LEN_DEF,
  localparam int AW = $clog2(SLOTS * PAT_LEN),
  localparam int SW = $clog2(SLOTS),
  localparam int LW = $clog2(PAT_LEN + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata,
  input  logic          len_we,
  input  logic [SW-1:0] len_waddr,
  input  logic [LW-1:0] len_wdata,
  input  logic [SW-1:0] len_raddr,
  output logic [LW-1:0] len_rdata
);

  logic [7:0]    bytes [SLOTS*PAT_LEN];
  logic [LW-1:0] lens  [SLOTS];

  always_ff @(posedge clk) begin
    if (we) bytes[waddr] <= wdata;
    rdata <= bytes[raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) lens[len_waddr] <= len_wdata;
    len_rdata <= lens[len_raddr];
  end

endmodule
